// ===== src/pmc_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet cursor block.
// Used by the front end, the packet queue, the cursor back end and the top level.
`default_nettype none

package pmc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DISP_W = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DISP_H = 2'd1;

	localparam int SIZE_BITS = 13;
	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd800;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd600;

	localparam int CURSOR_X_RESET = 400;
	localparam int CURSOR_Y_RESET = 300;

	// Header byte bit positions.
	localparam int SYNC_POS  = 3;
	localparam int XSIGN_POS = 4;
	localparam int YSIGN_POS = 5;
	localparam int XOVF_POS  = 6;
	localparam int YOVF_POS  = 7;

	localparam int BTN_BITS = 3;

	// Depth of the queue between the front end and the back end.
	localparam int PKT_DEPTH = 2;
	localparam int PKT_PTR_BITS = 1;

	// One complete, valid packet with 9-bit two's complement deltas.
	typedef struct packed {
		logic [BTN_BITS-1:0] btn;
		logic [8:0]          dx;
		logic [8:0]          dy;
	} pkt_t;

endpackage

`default_nettype wire

// ===== src/pmc_front.sv =====
// Front end: assembles three-byte packets from the byte stream and drops bad ones.
// Depends on pmc_pkg for the packet type and header bit positions.
`default_nettype none

module pmc_front import pmc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_take,
	input  wire logic [7:0] data_byte,
	output logic            pkt_push,
	output pkt_t            pkt
);

	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_X   = 2'd1;
	localparam logic [1:0] PH_Y   = 2'd2;

	logic [1:0] phase_q;
	logic [7:0] header_q;
	logic [7:0] x_byte_q;
	logic       last_byte;

	// Phase 3 never occurs but is treated like the Y byte phase.
	assign last_byte = (phase_q != PH_HDR) && (phase_q != PH_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			header_q <= '0;
			x_byte_q <= '0;
		end else if (byte_take) begin
			unique case (phase_q)
				PH_HDR: begin
					if (data_byte[SYNC_POS]) begin
						header_q <= data_byte;
						phase_q  <= PH_X;
					end
				end
				PH_X: begin
					x_byte_q <= data_byte;
					phase_q  <= PH_Y;
				end
				default: begin
					phase_q <= PH_HDR;
				end
			endcase
		end
	end

	// Packets with either overflow bit set are dropped here.
	assign pkt_push = byte_take && last_byte && !header_q[XOVF_POS] && !header_q[YOVF_POS];
	assign pkt.btn  = header_q[BTN_BITS-1:0];
	assign pkt.dx   = {header_q[XSIGN_POS], x_byte_q};
	assign pkt.dy   = {header_q[YSIGN_POS], data_byte};

endmodule

`default_nettype wire

// ===== src/pmc_fifo.sv =====
// Short packet queue between the front end and the cursor back end.
// Depends on pmc_pkg for the packet type and the queue depth.
`default_nettype none

module pmc_fifo import pmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire pkt_t wr_data,
	input  wire logic rd_en,
	output pkt_t      rd_data,
	output logic      q_full,
	output logic      q_empty
);

	localparam int CNT_BITS = $clog2(PKT_DEPTH + 1);

	pkt_t                    mem_q [PKT_DEPTH];
	logic [PKT_PTR_BITS-1:0] wr_ptr_q;
	logic [PKT_PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0]     count_q;

	assign q_full  = (count_q == CNT_BITS'(PKT_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PKT_PTR_BITS'(PKT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PKT_PTR_BITS'(PKT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/pmc_back.sv =====
// Back end: applies one packet to the cursor, clamps to the screen, holds the result item.
// Depends on pmc_pkg for the packet type and the cursor reset position.
`default_nettype none

module pmc_back import pmc_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [SIZE_BITS-1:0]  disp_w,
	input  wire logic [SIZE_BITS-1:0]  disp_h,
	input  wire pkt_t                  pkt,
	input  wire logic                  pkt_avail,
	output logic                       pkt_take,
	input  wire logic                  pop,
	output logic                       empty,
	output logic [COORD_BITS-1:0]      pos_x,
	output logic [COORD_BITS-1:0]      pos_y,
	output logic [COORD_BITS-1:0]      last_x,
	output logic [COORD_BITS-1:0]      last_y,
	output logic [BTN_BITS-1:0]        buttons,
	output logic [BTN_BITS-1:0]        last_buttons
);

	localparam int SW = (COORD_BITS + 2 > SIZE_BITS + 2) ? COORD_BITS + 2 : SIZE_BITS + 2;
	localparam logic signed [SW-1:0] CMAX = SW'((1 << COORD_BITS) - 1);

	logic                  out_v_q;
	logic [COORD_BITS-1:0] held_x_q;
	logic [COORD_BITS-1:0] held_y_q;
	logic [BTN_BITS-1:0]   held_btn_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [BTN_BITS-1:0]   btn_q;
	logic [BTN_BITS-1:0]   last_btn_q;

	logic signed [SW-1:0]  top_x, top_y;
	logic signed [SW-1:0]  sum_x, sum_y;
	logic [COORD_BITS-1:0] new_x, new_y;

	// Largest legal coordinate on each axis; a zero size behaves like a size of one.
	always_comb begin
		top_x = (disp_w == '0) ? '0 :
			$signed({{(SW-SIZE_BITS){1'b0}}, disp_w}) - SW'(1);
		if (top_x > CMAX) begin
			top_x = CMAX;
		end
		top_y = (disp_h == '0) ? '0 :
			$signed({{(SW-SIZE_BITS){1'b0}}, disp_h}) - SW'(1);
		if (top_y > CMAX) begin
			top_y = CMAX;
		end
	end

	// Screen Y grows downward, so a positive mouse dy moves the cursor up.
	always_comb begin
		sum_x = $signed({{(SW-COORD_BITS){1'b0}}, held_x_q})
			+ $signed({{(SW-9){pkt.dx[8]}}, pkt.dx});
		sum_y = $signed({{(SW-COORD_BITS){1'b0}}, held_y_q})
			- $signed({{(SW-9){pkt.dy[8]}}, pkt.dy});
		if (sum_x < 0) begin
			new_x = '0;
		end else if (sum_x > top_x) begin
			new_x = top_x[COORD_BITS-1:0];
		end else begin
			new_x = sum_x[COORD_BITS-1:0];
		end
		if (sum_y < 0) begin
			new_y = '0;
		end else if (sum_y > top_y) begin
			new_y = top_y[COORD_BITS-1:0];
		end else begin
			new_y = sum_y[COORD_BITS-1:0];
		end
	end

	assign pkt_take = pkt_avail && (!out_v_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			held_x_q   <= COORD_BITS'(CURSOR_X_RESET);
			held_y_q   <= COORD_BITS'(CURSOR_Y_RESET);
			held_btn_q <= '0;
		end else begin
			if (pkt_take) begin
				out_v_q    <= 1'b1;
				held_x_q   <= new_x;
				held_y_q   <= new_y;
				held_btn_q <= pkt.btn;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			pos_x_q    <= new_x;
			pos_y_q    <= new_y;
			last_x_q   <= held_x_q;
			last_y_q   <= held_y_q;
			btn_q      <= pkt.btn;
			last_btn_q <= held_btn_q;
		end
	end

	assign empty        = !out_v_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign last_x       = last_x_q;
	assign last_y       = last_y_q;
	assign buttons      = btn_q;
	assign last_buttons = last_btn_q;

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_take |=> out_v_q)
		else $error("result register not loaded after a packet was taken");

	a_held_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_take |=> (held_x_q == pos_x_q) && (held_y_q == pos_y_q) && (held_btn_q == btn_q))
		else $error("held cursor differs from the result just produced");

	a_last_is_prev: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_take |=> (last_x_q == $past(held_x_q)) && (last_btn_q == $past(held_btn_q)))
		else $error("previous cursor not reported with the result");

endmodule

`default_nettype wire

// ===== src/ps2_mouse_packet_cursor.sv =====
// PS/2 mouse packet cursor.
// Byte input: drive data_byte and push; the byte is taken at a clock edge with push high
// and full low. Bytes are grouped into header, X and Y packets; a header without the sync
// bit is dropped, and a packet with an overflow bit yields no result.
// Result output: while empty is low the oldest result (new and previous cursor position
// and buttons) is on the ports; it is taken at an edge with pop high.
// Configuration: cfg_valid with cfg_index and cfg_data writes the screen width (index 0)
// or the screen height (index 1); cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle sustained while full is low. The edge that takes a
// packet's last byte writes the packet queue, and the result register is then loaded
// from the queue through the cursor adder and clamp stage once it is empty or popped.
// Stall: while pop is low, the result register holds; further packets wait in the
// two-entry queue, and full rises once the queue is full, holding off new bytes.
// Reset: arst_n low empties the queue and result register, puts the cursor at (400, 300)
// with no buttons, and sets the screen to 800 by 600.
// Depends on pmc_pkg, pmc_front, pmc_fifo and pmc_back.
`default_nettype none

module ps2_mouse_packet_cursor import pmc_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [7:0]              data_byte,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [COORD_BITS-1:0]        pos_x,
	output logic [COORD_BITS-1:0]        pos_y,
	output logic [COORD_BITS-1:0]        last_x,
	output logic [COORD_BITS-1:0]        last_y,
	output logic [BTN_BITS-1:0]          buttons,
	output logic [BTN_BITS-1:0]          last_buttons,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [SIZE_BITS-1:0]    cfg_data
);

	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic                 byte_take;
	logic                 pkt_push;
	pkt_t                 pkt_in;
	pkt_t                 pkt_head;
	logic                 q_full;
	logic                 q_empty;
	logic                 pkt_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DISP_W: width_q  <= cfg_data;
				CFG_DISP_H: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign full      = q_full;
	assign byte_take = push && !full;

	pmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_take (byte_take),
		.data_byte (data_byte),
		.pkt_push  (pkt_push),
		.pkt       (pkt_in)
	);

	pmc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pkt_push),
		.wr_data (pkt_in),
		.rd_en   (pkt_take),
		.rd_data (pkt_head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	pmc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.disp_w       (width_q),
		.disp_h       (height_q),
		.pkt          (pkt_head),
		.pkt_avail    (!q_empty),
		.pkt_take     (pkt_take),
		.pop          (pop),
		.empty        (empty),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.last_x       (last_x),
		.last_y       (last_y),
		.buttons      (buttons),
		.last_buttons (last_buttons)
	);

endmodule

`default_nettype wire

// ===== tb/tb_ps2_mouse_packet_cursor.sv =====
// Self-checking testbench for ps2_mouse_packet_cursor: drives mouse bytes and screen-size
// writes, predicts each cursor result in a local packet tracker and checks it on arrival.
// Depends on pmc_pkg and the ps2_mouse_packet_cursor RTL.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor;
	import pmc_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTED = 40;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 2'd3;

	// Header bytes used by the directed tests.
	localparam logic [7:0] HDR_PLAIN     = 8'h08;
	localparam logic [7:0] HDR_NO_SYNC   = 8'hF7;
	localparam logic [7:0] HDR_MOVE_DOWN = 8'h28;
	localparam logic [7:0] HDR_MOVE_UP   = 8'h18;

	typedef enum logic [1:0] {WAIT_HEADER, WAIT_X, WAIT_Y} pkt_phase_t;

	typedef struct {
		logic [COORD_BITS-1:0] new_x;
		logic [COORD_BITS-1:0] new_y;
		logic [COORD_BITS-1:0] old_x;
		logic [COORD_BITS-1:0] old_y;
		logic [BTN_BITS-1:0]   new_btn;
		logic [BTN_BITS-1:0]   old_btn;
	} cursor_move_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic                    full;
	logic [7:0]              data_byte = 8'h00;
	logic                    empty;
	logic                    pop = 1'b0;
	logic [COORD_BITS-1:0]   pos_x;
	logic [COORD_BITS-1:0]   pos_y;
	logic [COORD_BITS-1:0]   last_x;
	logic [COORD_BITS-1:0]   last_y;
	logic [BTN_BITS-1:0]     buttons;
	logic [BTN_BITS-1:0]     last_buttons;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [SIZE_BITS-1:0]    cfg_data = '0;

	// Local copy of the packet tracker and cursor.
	pkt_phase_t            pkt_phase = WAIT_HEADER;
	logic [7:0]            hdr_byte = 8'h00;
	logic [7:0]            dx_byte = 8'h00;
	logic [COORD_BITS-1:0] cur_x = COORD_BITS'(CURSOR_X_RESET);
	logic [COORD_BITS-1:0] cur_y = COORD_BITS'(CURSOR_Y_RESET);
	logic [BTN_BITS-1:0]   cur_btn = '0;
	logic [SIZE_BITS-1:0]  scr_w = WIDTH_RESET;
	logic [SIZE_BITS-1:0]  scr_h = HEIGHT_RESET;

	cursor_move_t moves_due[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int error_count = 0;
	int bytes_sent = 0;
	int moves_taken = 0;
	int cfg_writes = 0;
	int full_stalls = 0;
	int quiet_cycles = 0;

	ps2_mouse_packet_cursor #(.COORD_BITS(COORD_BITS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.last_x       (last_x),
		.last_y       (last_y),
		.buttons      (buttons),
		.last_buttons (last_buttons),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [COORD_BITS-1:0] fit_to_screen(input int v,
			input logic [SIZE_BITS-1:0] size);
		int top;
		top = (size == 0) ? 0 : int'(size) - 1;
		if (top > COORD_MAX) top = COORD_MAX;
		if (v < 0) v = 0;
		if (v > top) v = top;
		return v[COORD_BITS-1:0];
	endfunction

	// Advances the tracker by one accepted byte and queues the cursor move it completes.
	function automatic void track_byte(input logic [7:0] b);
		int dx;
		int dy;
		cursor_move_t mv;
		case (pkt_phase)
			WAIT_HEADER: begin
				if (b[SYNC_POS]) begin
					hdr_byte = b;
					pkt_phase = WAIT_X;
				end
			end
			WAIT_X: begin
				dx_byte = b;
				pkt_phase = WAIT_Y;
			end
			default: begin
				pkt_phase = WAIT_HEADER;
				if (!hdr_byte[XOVF_POS] && !hdr_byte[YOVF_POS]) begin
					dx = $signed({hdr_byte[XSIGN_POS], dx_byte});
					dy = $signed({hdr_byte[YSIGN_POS], b});
					mv.old_x = cur_x;
					mv.old_y = cur_y;
					mv.old_btn = cur_btn;
					// Screen Y grows downward, so a positive dy moves the cursor up.
					mv.new_x = fit_to_screen(int'(cur_x) + dx, scr_w);
					mv.new_y = fit_to_screen(int'(cur_y) - dy, scr_h);
					mv.new_btn = hdr_byte[BTN_BITS-1:0];
					moves_due.push_back(mv);
					cur_x = mv.new_x;
					cur_y = mv.new_y;
					cur_btn = mv.new_btn;
				end
			end
		endcase
	endfunction

	function automatic logic [7:0] random_header();
		logic [7:0] h;
		h = 8'($urandom);
		h[SYNC_POS] = 1'b1;
		if ($urandom_range(9) != 0) begin
			h[XOVF_POS] = 1'b0;
			h[YOVF_POS] = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_size();
		case ($urandom_range(7))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'd8191;
			default: return SIZE_BITS'($urandom_range(4096, 1));
		endcase
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Offers one byte, with random idle cycles first, and waits until it is taken.
	// push is left high so that a following byte can go out on the next cycle.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
			data_byte <= 8'($urandom);
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		bytes_sent++;
		track_byte(b);
	endtask

	task automatic send_packet(input logic [7:0] h, input logic [7:0] x, input logic [7:0] y);
		send_byte(h);
		send_byte(x);
		send_byte(y);
	endtask

	// Stops the byte stream and waits until every predicted result has been taken.
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (moves_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_screen(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [SIZE_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_DISP_W: scr_w = val;
			CFG_DISP_H: scr_h = val;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_screen(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
		drain_results();
		write_screen(CFG_DISP_W, w);
		write_screen(CFG_DISP_H, h);
	endtask

	// Dropped headers, extreme deltas, button patterns 0, 2, 3 and 7, and both overflow bits.
	task automatic test_directed_bytes();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_byte(8'h00);
		send_byte(HDR_NO_SYNC);
		send_packet(HDR_PLAIN, 8'h00, 8'h00);
		send_packet(8'h0F, 8'hFF, 8'hFF);
		send_packet(8'h3F, 8'h00, 8'h00);
		send_packet(8'h4F, 8'h11, 8'h22);
		send_packet(8'h8A, 8'h33, 8'h44);
		send_packet(8'hFF, 8'hFF, 8'hFF);
		send_packet(8'h2B, 8'h01, 8'h80);
		drain_results();
	endtask

	// Zero, one, full-range and oversized screens, pushing the cursor toward both edges.
	task automatic test_screen_extremes();
		int w_list[6] = '{0, 1, 8191, 2, 4096, 800};
		int h_list[6] = '{0, 1, 8191, 4096, 2, 600};
		for (int i = 0; i < 6; i++) begin
			set_screen(SIZE_BITS'(w_list[i]), SIZE_BITS'(h_list[i]));
			repeat (3) send_packet(HDR_MOVE_DOWN, 8'hFF, 8'h00);
			repeat (3) send_packet(HDR_MOVE_UP, 8'h00, 8'hFF);
		end
		// A write to an unused index must leave both screen registers alone.
		drain_results();
		write_screen(CFG_IDX_UNUSED, 13'h1FFF);
		send_packet(HDR_MOVE_DOWN, 8'hFF, 8'h00);
		drain_results();
	endtask

	// Drive the cursor to the far corner of a large screen, then shrink the screen.
	task automatic test_screen_shrink();
		set_screen(13'd8191, 13'd4096);
		repeat (16) send_packet(HDR_MOVE_DOWN, 8'hFF, 8'h00);
		set_screen(13'd100, 13'd50);
		send_packet(HDR_PLAIN, 8'h00, 8'h00);
		repeat (2) send_packet(HDR_MOVE_UP, 8'h00, 8'hFF);
		drain_results();
	endtask

	// The receiver holds off while bytes keep coming, so the block fills and raises full.
	task automatic test_output_hold();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_screen(13'd800, 13'd600);
		@(posedge clk);
		hold_req = HOLD_CYCLES;
		repeat (30) send_packet(random_header(), 8'($urandom), 8'($urandom));
		drain_results();
	endtask

	// Mostly well-formed packets with random content, plus stray bytes and cut packets.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
		int sent;
		int pick;
		sent = 0;
		set_screen(pick_size(), pick_size());
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				send_packet(random_header(), 8'($urandom), 8'($urandom));
				sent += 3;
			end else if (pick < 90) begin
				send_byte(8'($urandom));
				sent += 1;
			end else begin
				send_byte(random_header());
				send_byte(8'($urandom));
				sent += 2;
			end
		end
		drain_results();
	endtask

	always @(negedge clk) begin : receiver
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		cursor_move_t want;
		if (arst_n && pop && !empty) begin
			moves_taken++;
			if (moves_due.size() == 0) begin
				report_error($sformatf("unexpected result at (%0d, %0d)", pos_x, pos_y));
			end else begin
				want = moves_due.pop_front();
				check_field("pos_x", int'(pos_x), int'(want.new_x));
				check_field("pos_y", int'(pos_y), int'(want.new_y));
				check_field("last_x", int'(last_x), int'(want.old_x));
				check_field("last_y", int'(last_y), int'(want.old_y));
				check_field("buttons", int'(buttons), int'(want.new_btn));
				check_field("last_buttons", int'(last_buttons), int'(want.old_btn));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout after %0d cycles with no handshake", QUIET_LIMIT);
			$display("tb_ps2_mouse_packet_cursor: errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_bytes();
		test_screen_extremes();
		test_screen_shrink();
		test_output_hold();
		test_random_traffic(11, 50, 110);
		test_random_traffic(50, 11, 110);
		test_random_traffic(0, 0, 110);

		$display("Run: %0d bytes, %0d cursor results, %0d register writes, %0d full stalls.",
			bytes_sent, moves_taken, cfg_writes, full_stalls);
		$display("Covered lost sync, overflow, cut packets, edge clamps and a long output hold.");
		if (error_count == 0) begin
			$display("tb_ps2_mouse_packet_cursor: clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("tb_ps2_mouse_packet_cursor: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pmc_pkg.sv
src/pmc_front.sv
src/pmc_fifo.sv
src/pmc_back.sv
src/ps2_mouse_packet_cursor.sv
tb/tb_ps2_mouse_packet_cursor.sv
